@@ design/jos_pkg.sv @@
// ----------------------------------------------------------------------------
// jos_pkg: shared types and constants for the Josephus survivor block
// Sizes of the alive bitmap, field widths, status codes, FSM states and the
// bitmap memory request.
// ----------------------------------------------------------------------------
package jos_pkg;

  localparam int MAX_MEMBERS = 1024;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = MAX_MEMBERS / WORD_BITS;
  localparam int ADDR_W      = $clog2(NUM_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int CNT_W       = $clog2(WORD_BITS + 1);
  localparam int LVL_W       = $clog2(BIT_W);

  localparam int SIZE_W      = 11;
  localparam int STEP_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int DIV_CNT_W   = $clog2(STEP_W);

  localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_ZERO_STEP = STATUS_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_NEXT,
    S_DIV,
    S_SCAN,
    S_PICK,
    S_CLEAR,
    S_DONE
  } jos_state_t;

  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wr_data;
  } jos_mem_req_t;

endpackage

@@ design/jos_if.sv @@
// ----------------------------------------------------------------------------
// jos_if: valid/ready channels of the Josephus survivor block
// Request channel carries circle size and step count, result channel carries
// the survivor number and status.
// ----------------------------------------------------------------------------
interface jos_req_if import jos_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] circle_size;
  logic [STEP_W-1:0] step_count;

  modport source (output valid, output circle_size, output step_count, input ready);
  modport sink   (input valid, input circle_size, input step_count, output ready);
endinterface

interface jos_res_if import jos_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SIZE_W-1:0]   survivor_number;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output survivor_number, output status, input ready);
  modport sink   (input valid, input survivor_number, input status, output ready);
endinterface

@@ design/jos_map_ram.sv @@
// ----------------------------------------------------------------------------
// jos_map_ram: alive bitmap storage
// One word of members per entry, single port, registered read data.
// ----------------------------------------------------------------------------
module jos_map_ram import jos_pkg::*; (
  input  logic                 clk,
  input  jos_mem_req_t         req,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    rd_data <= mem[req.addr];
  end

endmodule

@@ design/jos_mod_unit.sv @@
// ----------------------------------------------------------------------------
// jos_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; pulses done with the
// remainder of dividend by divisor.
// ----------------------------------------------------------------------------
module jos_mod_unit import jos_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [STEP_W-1:0]    dvd;
  logic [SIZE_W-1:0]    dvs;
  logic [SIZE_W-1:0]    part;
  logic [SIZE_W:0]      trial;

  // shift the next dividend bit into the partial remainder
  assign trial     = {part, dvd[STEP_W-1]};
  assign remainder = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(STEP_W - 1);
        dvd  <= dividend;
        dvs  <= divisor;
        part <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          part <= SIZE_W'(trial - {1'b0, dvs});
        end else begin
          part <= SIZE_W'(trial);
        end
        dvd <= dvd << 1;
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/josephus_survivor.sv @@
// ----------------------------------------------------------------------------
// josephus_survivor: last member standing in a Josephus circle
// An empty circle, a zero step or a circle of one goes straight to the result.
// Otherwise the bitmap is filled, then each elimination runs the remainder
// unit, reads the bitmap one word at a time up to the word of the target,
// picks the bit in that word and writes the word back; one more search ends.
// Throughput: one item at a time. Reset (rst, synchronous) clears control only.
// ----------------------------------------------------------------------------
module josephus_survivor import jos_pkg::*; (
  input logic      clk,
  input logic      rst,
  jos_req_if.sink  request,
  jos_res_if.source result
);

  // Members are kept as an alive bitmap in memory. The walk is tracked by
  // rank: s is the rank (among members still present) of the member where
  // counting starts. The leaving member has rank t = (s + (M-1) mod rem) mod
  // rem; the next count starts at the member that inherits rank t, or at
  // rank 0 when the last-ranked member left.

  jos_state_t state, state_next;

  logic [SIZE_W-1:0]    size_q;
  logic [STEP_W-1:0]    step_q;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    s_rank;
  logic [SIZE_W-1:0]    t_rank;
  logic [ADDR_W-1:0]    fill_addr;
  logic [ADDR_W-1:0]    scan_addr;
  logic [ADDR_W-1:0]    rd_word;
  logic                 rd_pending;
  logic [SIZE_W-1:0]    acc;
  logic [WORD_BITS-1:0] word_data;
  logic [WORD_BITS-1:0] win;
  logic [ADDR_W-1:0]    word_sel;
  logic [BIT_W-1:0]     bit_pos;
  logic [BIT_W-1:0]     local_rank;
  logic [LVL_W-1:0]     lvl;

  logic                 res_valid;
  logic [SIZE_W-1:0]    res_survivor;
  logic [STATUS_W-1:0]  res_status;
  logic [SIZE_W-1:0]    done_survivor;
  logic [STATUS_W-1:0]  done_status;

  // outcome of the item in progress, held apart from the result register
  logic [SIZE_W-1:0]    fin_survivor;
  logic [STATUS_W-1:0]  fin_status;

  jos_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] rd_data;
  logic                 div_start;
  logic                 div_done;
  logic [SIZE_W-1:0]    div_rem;

  logic [SIZE_W-1:0]    size_sat;
  logic                 accept;
  logic                 out_free;

  // bitmap fill mask
  logic [SIZE_W-1:0]    fill_base;
  logic                 fill_full;
  logic                 fill_none;
  logic [BIT_W-1:0]     fill_part;
  logic [WORD_BITS-1:0] fill_mask;

  // word scan
  logic [CNT_W-1:0]     word_pc;
  logic [SIZE_W:0]      acc_sum;
  logic                 hit;

  // bit pick
  logic [BIT_W-1:0]     half;
  logic [WORD_BITS-1:0] low_mask;
  logic [CNT_W-1:0]     low_pc;

  // rank of the leaving member
  logic [SIZE_W-1:0]    t_sum;
  logic [SIZE_W-1:0]    t_calc;

  jos_map_ram u_map (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  jos_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (step_q - STEP_W'(1)),
    .divisor   (rem),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign size_sat = (request.circle_size > SIZE_W'(MAX_MEMBERS)) ?
                    SIZE_W'(MAX_MEMBERS) : request.circle_size;
  assign accept   = request.valid && request.ready;
  assign out_free = !res_valid || result.ready;

  assign result.valid           = res_valid;
  assign result.survivor_number = res_survivor;
  assign result.status          = res_status;

  // Set bits for members below the circle size, clear the rest.
  assign fill_base = SIZE_W'({fill_addr, {BIT_W{1'b0}}});
  assign fill_full = {1'b0, size_q} >= ({1'b0, fill_base} + (SIZE_W + 1)'(WORD_BITS));
  assign fill_none = size_q <= fill_base;
  assign fill_part = BIT_W'(size_q - fill_base);
  assign fill_mask = fill_full ? {WORD_BITS{1'b1}} :
                     fill_none ? {WORD_BITS{1'b0}} :
                     ~({WORD_BITS{1'b1}} << fill_part);

  // The target lies in the word where the running count passes t.
  assign word_pc = CNT_W'($countones(rd_data));
  assign acc_sum = {1'b0, acc} + (SIZE_W + 1)'(word_pc);
  assign hit     = acc_sum > {1'b0, t_rank};

  // Halve the window each cycle, following the half that holds the rank.
  assign half     = BIT_W'((WORD_BITS / 2) >> lvl);
  assign low_mask = ~({WORD_BITS{1'b1}} << half);
  assign low_pc   = CNT_W'($countones(win & low_mask));

  // s < rem and the remainder < rem, so one subtract wraps the sum.
  assign t_sum  = s_rank + div_rem;
  assign t_calc = (t_sum >= rem) ? (t_sum - rem) : t_sum;

  // Immediate results straight from the request.
  always_comb begin
    done_survivor = '0;
    done_status   = STATUS_OK;
    if (size_sat == '0) begin
      done_status = STATUS_EMPTY;
    end else if (request.step_count == '0) begin
      done_status = STATUS_ZERO_STEP;
    end else begin
      done_survivor = SIZE_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (request.valid) begin
          if (size_sat inside {SIZE_W'(0), SIZE_W'(1)} || request.step_count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (fill_addr == ADDR_W'(NUM_WORDS - 1)) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        state_next = (rem == SIZE_W'(1)) ? S_SCAN : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_pending && hit) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (lvl == LVL_W'(BIT_W - 1)) begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        state_next = (rem == SIZE_W'(1)) ? S_DONE : S_NEXT;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs: request handshake, divider start, bitmap port.
  always_comb begin
    request.ready   = 1'b0;
    div_start       = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.addr    = scan_addr;
    mem_req.wr_data = fill_mask;
    case (state)
      S_IDLE: begin
        request.ready = 1'b1;
      end
      S_FILL: begin
        mem_req.wr_en = 1'b1;
        mem_req.addr  = fill_addr;
      end
      S_NEXT: begin
        div_start = (rem != SIZE_W'(1));
      end
      S_CLEAR: begin
        // drop the leaving member; the survivor itself stays
        if (rem != SIZE_W'(1)) begin
          mem_req.wr_en   = 1'b1;
          mem_req.addr    = word_sel;
          mem_req.wr_data = word_data & ~(WORD_BITS'(1) << bit_pos);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      fill_addr <= '0;
    end else begin
      state <= state_next;
      // load a new result when the register frees up, else drop a taken one
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            size_q       <= size_sat;
            step_q       <= request.step_count;
            rem          <= size_sat;
            s_rank       <= '0;
            fill_addr    <= '0;
            fin_survivor <= done_survivor;
            fin_status   <= done_status;
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + ADDR_W'(1);
        end
        S_NEXT: begin
          // last member left: search for rank zero
          t_rank     <= '0;
          scan_addr  <= '0;
          rd_pending <= 1'b0;
          acc        <= '0;
        end
        S_DIV: begin
          t_rank <= t_calc;
        end
        S_SCAN: begin
          scan_addr  <= scan_addr + ADDR_W'(1);
          rd_word    <= scan_addr;
          rd_pending <= 1'b1;
          if (rd_pending) begin
            if (hit) begin
              word_data  <= rd_data;
              win        <= rd_data;
              word_sel   <= rd_word;
              local_rank <= BIT_W'(t_rank - acc);
              bit_pos    <= '0;
              lvl        <= '0;
            end else begin
              acc <= SIZE_W'(acc_sum);
            end
          end
        end
        S_PICK: begin
          lvl <= lvl + LVL_W'(1);
          if ({1'b0, local_rank} < low_pc) begin
            win <= win & low_mask;
          end else begin
            win        <= win >> half;
            local_rank <= BIT_W'(local_rank - low_pc);
            bit_pos    <= bit_pos + half;
          end
        end
        S_CLEAR: begin
          if (rem == SIZE_W'(1)) begin
            fin_survivor <= SIZE_W'({word_sel, bit_pos}) + SIZE_W'(1);
            fin_status   <= STATUS_OK;
          end else begin
            rem    <= rem - SIZE_W'(1);
            s_rank <= (t_rank == rem - SIZE_W'(1)) ? '0 : t_rank;
          end
        end
        S_DONE: begin
          // hand the outcome over once the result register is free
          if (out_free) begin
            res_survivor <= fin_survivor;
            res_status   <= fin_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // one item at a time: an accepted request closes the input at once
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !request.ready)
    else $error("request accepted while an item is in progress");

  // the bitmap is written only while filling or removing a member
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == S_FILL || state == S_CLEAR))
    else $error("bitmap written outside fill or clear");

  // the remainder unit only finishes while its result is awaited
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("remainder done outside divide phase");

  // a good result always names a member
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == STATUS_OK) |-> res_survivor != '0)
    else $error("ok status with survivor zero");

endmodule
